FILE: rtl/tkw_pkg.sv
`default_nettype none

package tkw_pkg;

    localparam int TABLE_SIZE = 1024;
    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int LOW_W = IDX_W + 16;

    localparam int TOTAL_W = 24;
    localparam int INC_W = 40;
    localparam int COUNT_W = 25;
    localparam int AMP_W = 17;
    localparam int COS_W = 18;
    localparam int CFG_DATA_W = 40;
    localparam int CFG_IDX_W = 2;

    localparam logic [AMP_W-1:0] AMP_ONE = 17'h10000;
    localparam logic [INC_W-1:0] RISE_OFFSET = INC_W'(TABLE_SIZE / 2) << 16;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 24'd48000;
    localparam logic [TOTAL_W-1:0] TAPER_RESET = 24'd24000;
    localparam logic [INC_W-1:0] INC_RESET = 40'd2796;
    localparam logic [INC_W-1:0] FALL_RESET = 40'd100663296;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOTAL,
        REG_TAPER,
        REG_INC,
        REG_FALL
    } reg_idx_t;

    typedef enum logic [2:0] {
        KIND_ZERO,
        KIND_ONE,
        KIND_RISE,
        KIND_FALL,
        KIND_HOLD
    } kind_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
    } stage_ctl_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [TOTAL_W-1:0] taper;
        logic [INC_W-1:0]   inc;
        logic [INC_W-1:0]   fall;
    } cfg_t;

    typedef logic signed [COS_W-1:0] rom_t [TABLE_SIZE];

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // octant-folded taylor series, q30 internally, rounded to q16
    function automatic rom_t build_rom();
        rom_t       r;
        logic [63:0] j;
        logic [63:0] theta;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] v;
        logic       neg;
        logic       use_sin;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            j = 64'(i);
            neg = 1'b0;
            use_sin = 1'b0;
            if (j > 64'(TABLE_SIZE / 2))
            begin
                j = 64'(TABLE_SIZE) - j;
            end
            if (j > 64'(TABLE_SIZE / 4))
            begin
                j = 64'(TABLE_SIZE / 2) - j;
                neg = 1'b1;
            end
            if (j > 64'(TABLE_SIZE / 8))
            begin
                j = 64'(TABLE_SIZE / 4) - j;
                use_sin = 1'b1;
            end
            theta = (j * TWO_PI_Q30 + 64'(TABLE_SIZE / 2)) / TABLE_SIZE;
            x2 = qmul(theta, theta);
            t = Q30_ONE;
            for (int k = 0; k < 6; k++)
            begin
                if (use_sin)
                begin
                    case (k)
                        0: t = Q30_ONE - qmul(x2, t) / 64'd156;
                        1: t = Q30_ONE - qmul(x2, t) / 64'd110;
                        2: t = Q30_ONE - qmul(x2, t) / 64'd72;
                        3: t = Q30_ONE - qmul(x2, t) / 64'd42;
                        4: t = Q30_ONE - qmul(x2, t) / 64'd20;
                        default: t = Q30_ONE - qmul(x2, t) / 64'd6;
                    endcase
                end
                else
                begin
                    case (k)
                        0: t = Q30_ONE - qmul(x2, t) / 64'd132;
                        1: t = Q30_ONE - qmul(x2, t) / 64'd90;
                        2: t = Q30_ONE - qmul(x2, t) / 64'd56;
                        3: t = Q30_ONE - qmul(x2, t) / 64'd30;
                        4: t = Q30_ONE - qmul(x2, t) / 64'd12;
                        default: t = Q30_ONE - qmul(x2, t) / 64'd2;
                    endcase
                end
            end
            v = use_sin ? qmul(theta, t) : t;
            v = (v + (64'd1 << 13)) >> 14;
            r[i] = neg ? -COS_W'(v) : COS_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tukey_window_generator.sv
`default_nettype none

// Tukey window source: one amplitude (unsigned Q1.16) per restart/advance request, with a
// wrap flag on the tick after the window end. A request can be taken in every cycle
// while the output is not stalled. Each request passes five register stages (counter
// stage, split 25x40 phase multiply, phase subtract, registered cosine ROM read, output
// register); an output stall holds each occupied stage and, once all stages are full,
// reaches in_stall in the same cycle. The sample counter itself updates in the acceptance
// cycle, so requests follow back to back. Configuration writes are always taken (cfg_ready
// is tied high) and must only be issued while no request is in flight; phase_increment
// and fall_offset are precomputed Q24.16 values.
module tukey_window_generator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              restart,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [tkw_pkg::AMP_W-1:0]              amplitude,
    output logic                                   wrapped,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tkw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tkw_pkg::CFG_DATA_W-1:0]    cfg_data
);

    tkw_pkg::cfg_t                     cfg_reg;
    tkw_pkg::stage_ctl_t               ctl1;
    tkw_pkg::stage_ctl_t               ctl3;
    tkw_pkg::stage_ctl_t               ctl4;
    logic [tkw_pkg::COUNT_W-1:0]       count1;
    logic                              neg3;
    logic [tkw_pkg::LOW_W-1:0]         low3;
    logic signed [tkw_pkg::COS_W-1:0]  cos4;
    logic                              ready_phase;
    logic                              ready_rom;
    logic                              ready_out;
    logic                              out_valid_reg;
    logic [tkw_pkg::AMP_W-1:0]         amp_reg;
    logic [tkw_pkg::AMP_W-1:0]         amp_next;
    logic                              wrapped_reg;
    logic                              wrapped_next;
    logic [tkw_pkg::AMP_W-1:0]         held_reg;
    logic [tkw_pkg::AMP_W-1:0]         held_next;
    logic signed [tkw_pkg::COS_W:0]    raised;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.total <= tkw_pkg::TOTAL_RESET;
            cfg_reg.taper <= tkw_pkg::TAPER_RESET;
            cfg_reg.inc <= tkw_pkg::INC_RESET;
            cfg_reg.fall <= tkw_pkg::FALL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (tkw_pkg::reg_idx_t'(cfg_index))
                tkw_pkg::REG_TOTAL: cfg_reg.total <= cfg_data[tkw_pkg::TOTAL_W-1:0];
                tkw_pkg::REG_TAPER: cfg_reg.taper <= cfg_data[tkw_pkg::TOTAL_W-1:0];
                tkw_pkg::REG_INC:   cfg_reg.inc <= cfg_data[tkw_pkg::INC_W-1:0];
                tkw_pkg::REG_FALL:  cfg_reg.fall <= cfg_data[tkw_pkg::INC_W-1:0];
            endcase
        end
    end

    tkw_sequencer u_sequencer (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .restart    (restart),
        .cfg        (cfg_reg),
        .ready_down (ready_phase),
        .in_stall   (in_stall),
        .ctl        (ctl1),
        .count      (count1)
    );

    tkw_phase u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_up     (ctl1),
        .count      (count1),
        .cfg        (cfg_reg),
        .ready_down (ready_rom),
        .ready_up   (ready_phase),
        .ctl        (ctl3),
        .neg        (neg3),
        .low        (low3)
    );

    tkw_cos_rom u_cos_rom (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_up     (ctl3),
        .neg        (neg3),
        .low        (low3),
        .ready_down (ready_out),
        .ready_up   (ready_rom),
        .ctl        (ctl4),
        .cosine     (cos4)
    );

    assign ready_out = !out_valid_reg || !out_stall;

    // (1 + cos) / 2 rounded half up
    always_comb
    begin
        raised = {2'b0, tkw_pkg::AMP_ONE} + {cos4[tkw_pkg::COS_W-1], cos4}
            + {{tkw_pkg::COS_W{1'b0}}, 1'b1};
        held_next = held_reg;
        wrapped_next = 1'b0;
        case (ctl4.kind) inside
            tkw_pkg::KIND_ZERO: held_next = '0;
            tkw_pkg::KIND_ONE:  held_next = tkw_pkg::AMP_ONE;
            tkw_pkg::KIND_RISE,
            tkw_pkg::KIND_FALL: held_next = raised[tkw_pkg::AMP_W:1];
            tkw_pkg::KIND_HOLD: wrapped_next = 1'b1;
            default:            held_next = held_reg;
        endcase
        amp_next = held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_reg <= '0;
        end
        else if (ready_out)
        begin
            out_valid_reg <= ctl4.valid;
            if (ctl4.valid)
                held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_out)
        begin
            amp_reg <= amp_next;
            wrapped_reg <= wrapped_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign amplitude = amp_reg;
    assign wrapped = wrapped_reg;

    a_amp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> amplitude <= tkw_pkg::AMP_ONE)
        else $error("amplitude above one");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        ctl4.valid && !out_valid_reg |=> out_valid_reg)
        else $error("cosine stage result not moved to output");

    a_wrap_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ready_out && ctl4.valid && ctl4.kind == tkw_pkg::KIND_HOLD |=> $stable(held_reg))
        else $error("held amplitude changed on wrap");

endmodule

`default_nettype wire

FILE: rtl/tkw_sequencer.sv
`default_nettype none

module tkw_sequencer (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         restart,
    input  wire tkw_pkg::cfg_t                cfg,
    input  wire logic                         ready_down,
    output logic                              in_stall,
    output tkw_pkg::stage_ctl_t               ctl,
    output logic [tkw_pkg::COUNT_W-1:0]       count
);

    logic [tkw_pkg::COUNT_W-1:0] count_reg;
    logic [tkw_pkg::COUNT_W-1:0] count_next;
    logic [tkw_pkg::COUNT_W-1:0] s1_count_reg;
    tkw_pkg::stage_ctl_t         ctl_reg;
    tkw_pkg::kind_t              kind;
    logic                        ready_up;
    logic                        accept;
    logic [tkw_pkg::COUNT_W:0]   twice;
    logic                        in_rise;
    logic                        in_flat;
    logic                        in_fall;

    assign ready_up = !ctl_reg.valid || ready_down;
    assign in_stall = !ready_up;
    assign accept = in_valid && ready_up;

    always_comb
    begin
        twice = {count_reg, 1'b0};
        in_rise = twice < {2'b0, cfg.taper};
        in_flat = ({1'b0, twice} + {3'b0, cfg.taper}) <= {2'b0, cfg.total, 1'b0};
        in_fall = count_reg <= {1'b0, cfg.total};
        if (restart)
            kind = tkw_pkg::KIND_ZERO;
        else if (in_rise)
            kind = tkw_pkg::KIND_RISE;
        else if (in_flat)
            kind = tkw_pkg::KIND_ONE;
        else if (in_fall)
            kind = tkw_pkg::KIND_FALL;
        else
            kind = tkw_pkg::KIND_HOLD;
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (kind == tkw_pkg::KIND_ZERO || kind == tkw_pkg::KIND_HOLD)
                count_next = '0;
            else
                count_next = count_reg + {{(tkw_pkg::COUNT_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ctl_reg <= '{valid: 1'b0, kind: tkw_pkg::KIND_ZERO};
        end
        else
        begin
            count_reg <= count_next;
            if (ready_up)
            begin
                ctl_reg.valid <= in_valid;
                ctl_reg.kind <= kind;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up)
            s1_count_reg <= count_reg;
    end

    assign ctl = ctl_reg;
    assign count = s1_count_reg;

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && restart |=> count_reg == '0)
        else $error("restart did not clear the sample counter");

    a_advance_steps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && kind != tkw_pkg::KIND_ZERO && kind != tkw_pkg::KIND_HOLD
        |=> count_reg == $past(count_reg) + {{(tkw_pkg::COUNT_W-1){1'b0}}, 1'b1})
        else $error("sample counter did not step by one");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("sample counter moved without a request");

endmodule

`default_nettype wire

FILE: rtl/tkw_phase.sv
`default_nettype none

module tkw_phase (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tkw_pkg::stage_ctl_t          ctl_up,
    input  wire logic [tkw_pkg::COUNT_W-1:0]  count,
    input  wire tkw_pkg::cfg_t                cfg,
    input  wire logic                         ready_down,
    output logic                              ready_up,
    output tkw_pkg::stage_ctl_t               ctl,
    output logic                              neg,
    output logic [tkw_pkg::LOW_W-1:0]         low
);

    localparam int LO_W = tkw_pkg::COUNT_W + 32;
    localparam int HI_W = tkw_pkg::COUNT_W + tkw_pkg::INC_W - 32;
    localparam int PROD_W = tkw_pkg::COUNT_W + tkw_pkg::INC_W;

    tkw_pkg::stage_ctl_t          ctl2_reg;
    tkw_pkg::stage_ctl_t          ctl3_reg;
    logic [LO_W-1:0]              plo_reg;
    logic [HI_W-1:0]              phi_reg;
    logic                         neg_reg;
    logic [tkw_pkg::LOW_W-1:0]    low_reg;
    logic                         ready2;
    logic                         ready3;
    logic [tkw_pkg::INC_W-1:0]    off;
    logic [PROD_W-1:0]            prod;
    logic [PROD_W:0]              diff;

    assign ready3 = !ctl3_reg.valid || ready_down;
    assign ready2 = !ctl2_reg.valid || ready3;
    assign ready_up = ready2;

    always_comb
    begin
        off = (ctl2_reg.kind == tkw_pkg::KIND_RISE) ? tkw_pkg::RISE_OFFSET : cfg.fall;
        prod = {phi_reg, 32'b0} + {{(PROD_W - LO_W){1'b0}}, plo_reg};
        diff = {1'b0, prod} - {{(PROD_W + 1 - tkw_pkg::INC_W){1'b0}}, off};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '{valid: 1'b0, kind: tkw_pkg::KIND_ZERO};
            ctl3_reg <= '{valid: 1'b0, kind: tkw_pkg::KIND_ZERO};
        end
        else
        begin
            if (ready2)
                ctl2_reg <= ctl_up;
            if (ready3)
                ctl3_reg <= ctl2_reg;
        end
    end

    // split product: low 32 bits and high bits of the increment
    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            plo_reg <= LO_W'(count) * LO_W'(cfg.inc[31:0]);
            phi_reg <= HI_W'(count) * HI_W'(cfg.inc[tkw_pkg::INC_W-1:32]);
        end
        if (ready3)
        begin
            neg_reg <= diff[PROD_W];
            low_reg <= diff[tkw_pkg::LOW_W-1:0];
        end
    end

    assign ctl = ctl3_reg;
    assign neg = neg_reg;
    assign low = low_reg;

endmodule

`default_nettype wire

FILE: rtl/tkw_cos_rom.sv
`default_nettype none

module tkw_cos_rom (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tkw_pkg::stage_ctl_t          ctl_up,
    input  wire logic                         neg,
    input  wire logic [tkw_pkg::LOW_W-1:0]    low,
    input  wire logic                         ready_down,
    output logic                              ready_up,
    output tkw_pkg::stage_ctl_t               ctl,
    output logic signed [tkw_pkg::COS_W-1:0]  cosine
);

    localparam tkw_pkg::rom_t COS_ROM = tkw_pkg::build_rom();

    tkw_pkg::stage_ctl_t               ctl_reg;
    logic signed [tkw_pkg::COS_W-1:0]  data_reg;
    logic [tkw_pkg::LOW_W-1:0]         rounded;
    logic [tkw_pkg::IDX_W-1:0]         idx;

    assign ready_up = !ctl_reg.valid || ready_down;

    // negative phase truncates toward zero before folding
    always_comb
    begin
        rounded = low + {{tkw_pkg::IDX_W{1'b0}}, {16{neg}}};
        idx = rounded[tkw_pkg::LOW_W-1:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '{valid: 1'b0, kind: tkw_pkg::KIND_ZERO};
        else if (ready_up)
            ctl_reg <= ctl_up;
    end

    always_ff @(posedge clk)
    begin
        if (ready_up)
            data_reg <= COS_ROM[idx];
    end

    assign ctl = ctl_reg;
    assign cosine = data_reg;

endmodule

`default_nettype wire
